// File: design/ppg_pkg.sv
// Package for the paper passcode generator: payload types, constants,
// the AES S-box and the base-64 symbol table. No dependencies.
package ppg_pkg;

    localparam int MAX_COUNT       = 16;
    localparam int MAX_LENGTH      = 8;
    localparam int CHARS_PER_BLOCK = 21;
    localparam int ROUNDS          = 14;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_LENGTH = 3'd4;

    typedef struct packed {
        logic [4:0]  passcode_count;
        logic [63:0] first_number_high;
        logic [63:0] first_number_low;
    } ppg_in_t;

    typedef struct packed {
        logic        last_passcode;
        logic [63:0] passcode_text;
    } ppg_out_t;

    // Control from the sequencer to the AES round unit.
    typedef struct packed {
        logic load;
    } ppg_aes_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] symbol(input logic [5:0] d);
        logic [7:0] t [64];
        t = '{"!","#","%","+","2","3","4","5","6","7","8","9",":","=","?","@",
              "A","B","C","D","E","F","G","H","J","K","L","M","N","P","R","S",
              "T","U","V","W","X","Y","Z","a","b","c","d","e","f","g","h","i",
              "j","k","m","n","o","p","q","r","s","t","u","v","w","x","y","z"};
        return t[d];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Whole passcodes in one 21-character block for a clamped length of 1 to 8.
    function automatic logic [4:0] passcodes_per_block(input logic [3:0] len);
        logic [4:0] per;
        unique case (len)
            4'd1:    per = 5'd21;
            4'd2:    per = 5'd10;
            4'd3:    per = 5'd7;
            4'd4:    per = 5'd5;
            4'd5:    per = 5'd4;
            4'd6:    per = 5'd3;
            4'd7:    per = 5'd3;
            default: per = 5'd2;
        endcase
        return per;
    endfunction

endpackage

// File: design/ppg_aes.sv
// Iterative AES-256 round unit: one round per cycle; key steps on even rounds.
// Depends on ppg_pkg.
module ppg_aes (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppg_pkg::ppg_aes_ctl_t ctl,
    input  logic [255:0]          key,
    input  logic [127:0]          block_in,
    output logic [127:0]          block_out,
    output logic                  done
);
    import ppg_pkg::*;

    logic [127:0] state_reg, state_next;
    logic [255:0] rk_reg, rk_next;
    logic [3:0]   round_reg, round_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    logic [127:0] sb, sr, mc, rkey;
    logic [31:0]  w [8];
    logic [31:0]  t0, t1;

    // Round datapath on the current state; round key is the upper half of rk_reg
    // for odd rounds and the lower half (freshly made) for even rounds.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            sb[i*8 +: 8] = sbox(state_reg[i*8 +: 8]);
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                sr[(c*4+i)*8 +: 8] = sb[((((c+i)&3)*4)+i)*8 +: 8];
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sr[(c*4)*8 +: 8];
            a1 = sr[(c*4+1)*8 +: 8];
            a2 = sr[(c*4+2)*8 +: 8];
            a3 = sr[(c*4+3)*8 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[(c*4)*8 +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
            mc[(c*4+1)*8 +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            mc[(c*4+2)*8 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[(c*4+3)*8 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
    end

    // Key schedule: rk_reg holds words 8k..8k+7; on odd rounds the upper
    // 128 bits are words 4..7 and used directly; on even rounds the next
    // eight words are produced in full.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            w[i] = rk_reg[i*32 +: 32];
        t0 = {sbox(w[7][7:0]), sbox(w[7][31:24]), sbox(w[7][23:16]),
              sbox(w[7][15:8])} ^ {24'h0, rcon_reg};
        rk_next = rk_reg;
        rk_next[0 +: 32]  = w[0] ^ t0;
        rk_next[32 +: 32] = w[1] ^ w[0] ^ t0;
        rk_next[64 +: 32] = w[2] ^ w[1] ^ w[0] ^ t0;
        rk_next[96 +: 32] = w[3] ^ w[2] ^ w[1] ^ w[0] ^ t0;
        t1 = rk_next[96 +: 32];
        t1 = {sbox(t1[31:24]), sbox(t1[23:16]), sbox(t1[15:8]), sbox(t1[7:0])};
        rk_next[128 +: 32] = w[4] ^ t1;
        rk_next[160 +: 32] = w[5] ^ w[4] ^ t1;
        rk_next[192 +: 32] = w[6] ^ w[5] ^ w[4] ^ t1;
        rk_next[224 +: 32] = w[7] ^ w[6] ^ w[5] ^ w[4] ^ t1;
    end

    // Sequencer for the fourteen rounds.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        rcon_next  = rcon_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        rkey       = round_reg[0] ? rk_reg[255:128] : rk_next[127:0];
        if (ctl.load)
        begin
            state_next = block_in ^ key[127:0];
            round_next = 4'd1;
            rcon_next  = 8'h01;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            state_next = ((round_reg == 4'(ROUNDS)) ? sr : mc) ^ rkey;
            round_next = round_reg + 4'd1;
            if (!round_reg[0])
                rcon_next = xtime(rcon_reg);
            if (round_reg == 4'(ROUNDS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        round_reg <= round_next;
        rcon_reg  <= rcon_next;
        if (ctl.load)
            rk_reg <= key;
        else if (busy_reg && !round_reg[0])
            rk_reg <= rk_next;
    end

    assign block_out = state_reg;
    assign done      = done_reg;
endmodule

// File: design/ppg_divider.sv
// Bit-serial divider of the 128-bit first number by the passcodes per block.
// Depends on ppg_pkg.
module ppg_divider (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] dividend,
    input  logic [4:0]   divisor,
    output logic [127:0] quotient,
    output logic [4:0]   remainder,
    output logic         done
);
    import ppg_pkg::*;

    logic [127:0] q_reg, q_next;
    logic [4:0]   r_reg, r_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [5:0]   trial;

    // One restoring step per cycle, most significant bit first.
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[127]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 8'd128;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                r_next = 5'(trial - {1'b0, divisor});
                q_next = {q_reg[126:0], 1'b1};
            end
            else
            begin
                r_next = trial[4:0];
                q_next = {q_reg[126:0], 1'b0};
            end
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = done_reg;
endmodule

// File: design/paper_passcode_generator_core.sv
// Top level of the paper passcode generator; instantiates ppg_divider and
// ppg_aes. Depends on ppg_pkg.
//
// A request is taken when start is high and busy is low. The first number is
// divided by the passcodes per block in a bit-serial divider (128 steps), then
// each block is encrypted by the AES unit one round per cycle, and its
// characters are taken one per cycle. The passcodes ahead of the first number
// in its block are built and skipped; busy stays high until the S_EMIT state
// has delivered the last passcode. Each delivered passcode appears on result
// for exactly one cycle with result_valid high, registered from S_EMIT; the
// receiver cannot stall it. Configuration should be written only while
// busy is low.
module paper_passcode_generator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ppg_pkg::ppg_in_t   request,
    output logic               result_valid,
    output ppg_pkg::ppg_out_t  result,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import ppg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_AES   = 5'b00100,
        S_CHAR  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [255:0]  key_reg;
    logic [3:0]    len_cfg_reg;
    logic [3:0]    len_reg;
    logic [4:0]    per_reg;
    logic [4:0]    count_reg, count_next;
    logic [4:0]    skip_reg, skip_next;
    logic [4:0]    pidx_reg, pidx_next;
    logic [3:0]    k_reg, k_next;
    logic [127:0]  blk_reg, blk_next;
    logic [127:0]  ciph_reg, ciph_next;
    logic [63:0]   text_reg, text_next;
    logic          div_start, div_done, aes_done;
    logic [127:0]  div_q, aes_out;
    logic [4:0]    div_r;
    ppg_aes_ctl_t  aes_ctl;
    logic [3:0]    len_eff;
    logic [4:0]    cnt_eff;
    logic          out_valid_reg, out_valid_next;
    ppg_out_t      out_reg, out_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            len_cfg_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY0:   key_reg[63:0]    <= cfg_data;
                REG_KEY1:   key_reg[127:64]  <= cfg_data;
                REG_KEY2:   key_reg[191:128] <= cfg_data;
                REG_KEY3:   key_reg[255:192] <= cfg_data;
                REG_LENGTH: len_cfg_reg      <= cfg_data[3:0];
                default:    ;
            endcase
        end
    end

    // Clamp length and count as the request is taken.
    always_comb
    begin
        len_eff = len_cfg_reg;
        if (len_cfg_reg == 4'd0)
            len_eff = 4'd1;
        else if (len_cfg_reg > 4'(MAX_LENGTH))
            len_eff = 4'(MAX_LENGTH);
        cnt_eff = request.passcode_count;
        if (cnt_eff > 5'(MAX_COUNT))
            cnt_eff = 5'(MAX_COUNT);
    end

    // The divisor is captured in per_reg at the edge that starts the divider.
    ppg_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  ({request.first_number_high, request.first_number_low}),
        .divisor   (per_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // The block number is taken from blk_next so that a load straight after
    // the division sees the fresh quotient.
    ppg_aes u_aes (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (aes_ctl),
        .key       (key_reg),
        .block_in  (blk_next),
        .block_out (aes_out),
        .done      (aes_done)
    );

    // Main sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        skip_next      = skip_reg;
        pidx_next      = pidx_reg;
        k_next         = k_reg;
        blk_next       = blk_reg;
        ciph_next      = ciph_reg;
        text_next      = text_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        div_start      = 1'b0;
        aes_ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && cnt_eff != 5'd0)
                begin
                    div_start  = 1'b1;
                    count_next = cnt_eff;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    blk_next     = div_q;
                    skip_next    = div_r;
                    aes_ctl.load = 1'b1;
                    state_next   = S_AES;
                end
            end
            S_AES:
            begin
                if (aes_done)
                begin
                    ciph_next  = aes_out;
                    blk_next   = blk_reg + 128'd1;
                    pidx_next  = '0;
                    k_next     = '0;
                    text_next  = '0;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                // One character per cycle from the low digit of the cipher.
                text_next = text_reg | (64'(symbol(ciph_reg[5:0])) << {k_reg[2:0], 3'b000});
                ciph_next = ciph_reg >> 6;
                k_next    = k_reg + 4'd1;
                if (k_reg + 4'd1 == len_reg)
                    state_next = S_EMIT;
            end
            default:
            begin
                // S_EMIT: deliver or skip the finished passcode.
                if (skip_reg != 5'd0)
                    skip_next = skip_reg - 5'd1;
                else
                begin
                    out_valid_next         = 1'b1;
                    out_next.passcode_text = text_reg;
                    out_next.last_passcode = (count_reg == 5'd1);
                    count_next             = count_reg - 5'd1;
                end
                k_next    = '0;
                text_next = '0;
                pidx_next = pidx_reg + 5'd1;
                if (skip_reg == 5'd0 && count_reg == 5'd1)
                    state_next = S_IDLE;
                else if (pidx_reg + 5'd1 == per_reg)
                begin
                    aes_ctl.load = 1'b1;
                    state_next   = S_AES;
                end
                else
                    state_next = S_CHAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        skip_reg  <= skip_next;
        pidx_reg  <= pidx_next;
        k_reg     <= k_next;
        blk_reg   <= blk_next;
        ciph_reg  <= ciph_next;
        text_reg  <= text_next;
        out_reg   <= out_next;
        if (state_reg == S_IDLE)
        begin
            len_reg <= len_eff;
            per_reg <= passcodes_per_block(len_eff);
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
endmodule

// File: verif/paper_passcode_generator_core_test.sv
// Self-checking testbench for paper_passcode_generator_core: AES-256 based
// passcode requests are driven, directed and at random, and every passcode is
// predicted and compared. Depends on ppg_pkg and the design files.
module paper_passcode_generator_core_test;
    import ppg_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 400;
    localparam string ALPHABET =
        "!#%+23456789:=?@ABCDEFGHJKLMNPRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    ppg_in_t     request;
    logic        result_valid;
    ppg_out_t    result;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // Shadow copy of the configuration registers.
    logic [63:0] key_shadow [4];
    logic [3:0]  length_shadow;
    logic [7:0]  round_key [240];

    ppg_in_t     pending_requests [$];
    ppg_out_t    expected_passcodes [$];
    int          requests_queued;
    int          requests_taken;
    int          error_count;
    int          cycle_count;
    int          gap_left;
    bit          no_gaps;
    logic        took_request;

    logic [7:0] aes_sbox [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    paper_passcode_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Builds the 60-word AES-256 schedule from the shadow key.
    task automatic build_schedule();
        logic [7:0] w [4];
        logic [7:0] r;
        for (int i = 0; i < 32; i++)
        begin
            round_key[i] = key_shadow[i >> 3][8 * (i & 7) +: 8];
        end
        for (int i = 8; i < 60; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                w[j] = round_key[(i - 1) * 4 + j];
            end
            if ((i & 7) == 0)
            begin
                r = w[0];
                w[0] = aes_sbox[w[1]] ^ (8'h01 << ((i >> 3) - 1));
                w[1] = aes_sbox[w[2]];
                w[2] = aes_sbox[w[3]];
                w[3] = aes_sbox[r];
            end
            else if ((i & 7) == 4)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    w[j] = aes_sbox[w[j]];
                end
            end
            for (int j = 0; j < 4; j++)
            begin
                round_key[i * 4 + j] = round_key[(i - 8) * 4 + j] ^ w[j];
            end
        end
    endtask

    // Encrypts one little-endian block number with the current schedule.
    function automatic logic [127:0] encrypt_block_number(input logic [127:0] plain);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, mix;
        logic [127:0] cipher;
        for (int i = 0; i < 16; i++)
        begin
            s[i] = plain[8 * i +: 8] ^ round_key[i];
        end
        for (int r = 1; r <= 14; r++)
        begin
            for (int i = 0; i < 16; i++)
            begin
                s[i] = aes_sbox[s[i]];
            end
            for (int c = 0; c < 4; c++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    t[c * 4 + i] = s[((c + i) & 3) * 4 + i];
                end
            end
            s = t;
            if (r != 14)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[c * 4];
                    a1 = s[c * 4 + 1];
                    a2 = s[c * 4 + 2];
                    a3 = s[c * 4 + 3];
                    mix = a0 ^ a1 ^ a2 ^ a3;
                    s[c * 4]     = a0 ^ mix ^ gf_double(a0 ^ a1);
                    s[c * 4 + 1] = a1 ^ mix ^ gf_double(a1 ^ a2);
                    s[c * 4 + 2] = a2 ^ mix ^ gf_double(a2 ^ a3);
                    s[c * 4 + 3] = a3 ^ mix ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
            begin
                s[i] = s[i] ^ round_key[r * 16 + i];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            cipher[8 * i +: 8] = s[i];
        end
        return cipher;
    endfunction

    // Works out every passcode one request produces.
    task automatic predict_passcodes(input ppg_in_t req);
        int len, count, per_block, skip, made, p;
        logic [127:0] block_number, cipher;
        ppg_out_t code;
        len = length_shadow;
        count = req.passcode_count;
        if (len == 0)
        begin
            len = 1;
        end
        if (len > MAX_LENGTH)
        begin
            len = MAX_LENGTH;
        end
        if (count > MAX_COUNT)
        begin
            count = MAX_COUNT;
        end
        per_block = CHARS_PER_BLOCK / len;
        block_number = {req.first_number_high, req.first_number_low} / per_block;
        skip = int'({req.first_number_high, req.first_number_low} % per_block);
        build_schedule();
        made = 0;
        while (made < count)
        begin
            cipher = encrypt_block_number(block_number);
            block_number = block_number + 1;
            p = 0;
            while (p < per_block && made < count)
            begin
                code = '0;
                for (int k = 0; k < len; k++)
                begin
                    code.passcode_text[8 * k +: 8] = ALPHABET[cipher[5:0]];
                    cipher = cipher >> 6;
                end
                if (skip > 0)
                begin
                    skip--;
                end
                else
                begin
                    made++;
                    code.last_passcode = (made == count);
                    expected_passcodes.push_back(code);
                end
                p++;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic queue_request(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] count);
        ppg_in_t req;
        req.first_number_low = lo;
        req.first_number_high = hi;
        req.passcode_count = count;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    task automatic write_register(input logic [2:0] index, input logic [63:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
    endtask

    // Waits until every request is taken, every passcode has come out and
    // the block has had time to finish any request without passcodes.
    task automatic wait_until_idle();
        while (requests_taken != requests_queued || expected_passcodes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Shadow registers, request capture and the cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        took_request <= rst_n && start && !busy;
        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                REG_KEY0:   key_shadow[0] = cfg_data;
                REG_KEY1:   key_shadow[1] = cfg_data;
                REG_KEY2:   key_shadow[2] = cfg_data;
                REG_KEY3:   key_shadow[3] = cfg_data;
                REG_LENGTH: length_shadow = cfg_data[3:0];
                default:    ;
            endcase
        end
        if (rst_n && start && !busy)
        begin
            predict_passcodes(request);
            requests_taken <= requests_taken + 1;
        end
    end

    // Driver: presents the next pending request after a random gap, or none with no_gaps.
    always @(negedge clk)
    begin
        if (rst_n && !(start && !took_request))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                request <= pending_requests.pop_front();
                start <= 1'b1;
                gap_left <= no_gaps ? 0 : $urandom_range(0, 8);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each passcode transaction against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_passcodes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected passcode %h", result.passcode_text));
            end
            else
            begin
                if (result.passcode_text !== expected_passcodes[0].passcode_text)
                begin
                    report_mismatch($sformatf("passcode_text %h, expected %h",
                        result.passcode_text, expected_passcodes[0].passcode_text));
                end
                if (result.last_passcode !== expected_passcodes[0].last_passcode)
                begin
                    report_mismatch($sformatf("last_passcode %b, expected %b",
                        result.last_passcode, expected_passcodes[0].last_passcode));
                end
                void'(expected_passcodes.pop_front());
            end
        end
    end

    // Stimulus: directed requests under reset configuration, then phases.
    initial
    begin
        logic [3:0] lengths [10];
        logic [63:0] lo, hi;
        int pick;
        lengths = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd12};
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY0;
        cfg_data = '0;
        key_shadow = '{default: '0};
        length_shadow = 4'd4;
        requests_queued = 0;
        requests_taken = 0;
        error_count = 0;
        cycle_count = 0;
        gap_left = 0;
        no_gaps = 1'b0;
        took_request = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Extremes of the first number, and zero and overlarge counts.
        queue_request('0, '0, 5'd1);
        queue_request('0, '0, 5'd16);
        queue_request('1, '1, 5'd3);
        queue_request('1, '1, 5'd31);
        queue_request(64'd7, '0, 5'd0);
        queue_request(64'd4, '0, 5'd17);
        queue_request(64'hFFFF_FFFF, 64'h1, 5'd5);
        queue_request('1, '0, 5'd2);
        queue_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 5'd9);
        queue_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 5'd16);
        wait_until_idle();

        for (int phase = 0; phase < 10; phase++)
        begin
            no_gaps = (phase % 3 == 2);
            for (int k = 0; k < 4; k++)
            begin
                write_register(REG_KEY0 + 3'(k), phase == 0 ? '1 :
                               phase == 1 ? '0 : random_word());
            end
            write_register(REG_LENGTH, {random_word()} & ~64'hF | 64'(lengths[phase]));
            @(negedge clk);
            cfg_we <= 1'b0;
            if (phase == 1)
            begin
                queue_request('0, '0, 5'd16);
                queue_request('1, '1, 5'd16);
            end
            for (int n = 0; n < 49; n++)
            begin
                pick = $urandom_range(0, 9);
                lo = random_word();
                hi = random_word();
                if (pick == 0)
                begin
                    hi = '1;
                    lo = '1 - 64'($urandom_range(0, 40));
                end
                else if (pick < 4)
                begin
                    hi = '0;
                    lo = 64'($urandom_range(0, 200));
                end
                pick = $urandom_range(0, 19);
                queue_request(lo, hi, pick == 0 ? 5'd0 :
                              pick == 1 ? 5'($urandom_range(17, 31)) :
                              5'($urandom_range(1, 16)));
            end
            wait_until_idle();
        end

        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
design/ppg_pkg.sv
design/ppg_aes.sv
design/ppg_divider.sv
design/paper_passcode_generator_core.sv
verif/paper_passcode_generator_core_test.sv
